FILE: sv/htpd_pkg.sv
// shared types and constants for the header/trailer packet deframer
`default_nettype none

package htpd_pkg;

  // transaction opcodes on the input channel
  typedef enum logic [1:0] {
    ACT_BYTE     = 2'd0,
    ACT_READ     = 2'd1,
    ACT_RELEASE  = 2'd2,
    ACT_LINE_ERR = 2'd3
  } htpd_action_t;

  // framing phases, one-hot
  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_SYNC = 4'b0010,
    PH_BODY = 4'b0100,
    PH_TAIL = 4'b1000
  } htpd_phase_t;

  // frame delimiter bytes
  localparam logic [7:0] HDR_SYNC0 = 8'hAA;
  localparam logic [7:0] HDR_SYNC1 = 8'h55;
  localparam logic [7:0] TRL_CR    = 8'h0D;
  localparam logic [7:0] TRL_LF    = 8'h0A;

  // field widths fixed by the channel format
  localparam int unsigned IDX_W = 6;
  localparam int unsigned LEN_W = 6;

  // framer status toward the pipeline control
  typedef struct packed {
    logic             held_cur;  // packet held before this transaction
    logic             held_nxt;  // packet held after this transaction
    logic [LEN_W-1:0] len_nxt;   // held length after this transaction, 0 if none
    logic             rd_hit;    // read index falls inside a held packet
  } htpd_status_t;

endpackage

`default_nettype wire

FILE: sv/htpd_in_if.sv
// input channel: received bytes, payload reads, release and line error
`default_nettype none

interface htpd_in_if;
  import htpd_pkg::*;

  logic               valid;
  logic               ready;
  htpd_action_t       action;
  logic [7:0]         byte_value;
  logic [IDX_W-1:0]   read_index;

  modport source (output valid, output action, output byte_value, output read_index,
                  input ready);
  modport sink   (input valid, input action, input byte_value, input read_index,
                  output ready);
endinterface

`default_nettype wire

FILE: sv/htpd_out_if.sv
// result channel: packet status and read data
`default_nettype none

interface htpd_out_if;
  import htpd_pkg::*;

  logic               valid;
  logic               ready;
  logic               packet_ready;
  logic [LEN_W-1:0]   packet_length;
  logic [7:0]         read_data;
  logic               read_valid;

  modport source (output valid, output packet_ready, output packet_length,
                  output read_data, output read_valid, input ready);
  modport sink   (input valid, input packet_ready, input packet_length,
                  input read_data, input read_valid, output ready);
endinterface

`default_nettype wire

FILE: sv/htpd_store.sv
// payload byte store: one write port, one registered read port
`default_nettype none

module htpd_store #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned AW           = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [7:0]         rd_data
);

  logic [7:0] mem [BUFFER_DEPTH];
  logic [7:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: sv/htpd_framer.sv
// frame state machine, fill counter and held packet bookkeeping
`default_nettype none

module htpd_framer #(
  parameter int unsigned BUFFER_DEPTH = 64,
  parameter int unsigned LW           = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        commit,
  input  wire htpd_pkg::htpd_action_t      action,
  input  wire logic [7:0]                  byte_value,
  input  wire logic [htpd_pkg::IDX_W-1:0]  read_index,
  output htpd_pkg::htpd_status_t           status,
  output logic                             wr_en,
  output logic [LW-1:0]                    wr_addr,
  output logic [7:0]                       wr_data,
  output logic [LW-1:0]                    rd_addr
);
  import htpd_pkg::*;

  localparam int unsigned CW = LW + IDX_W + 1;

  htpd_phase_t phase_r, phase_nxt;
  logic [LW-1:0] fill_r, fill_nxt;
  logic [LW-1:0] hlen_r, hlen_nxt;
  logic          held_r, held_nxt;
  logic          disc_r, disc_nxt;

  logic [CW-1:0]       idx_w;
  logic [CW-1:0]       hlen_w;
  logic [LW+LEN_W-1:0] len_ext;

  // next state for one committed transaction
  always_comb begin
    phase_nxt = phase_r;
    fill_nxt  = fill_r;
    hlen_nxt  = hlen_r;
    held_nxt  = held_r;
    disc_nxt  = disc_r;
    wr_en     = 1'b0;
    if (commit) begin
      case (action)
        ACT_BYTE: begin
          case (phase_r)
            PH_HUNT: begin
              if (byte_value == HDR_SYNC0) phase_nxt = PH_SYNC;
            end
            PH_SYNC: begin
              if (byte_value == HDR_SYNC1) begin
                phase_nxt = PH_BODY;
                fill_nxt  = '0;
                disc_nxt  = held_r;
              end else if (byte_value != HDR_SYNC0) begin
                phase_nxt = PH_HUNT;
              end
            end
            PH_BODY: begin
              if (byte_value == TRL_CR) begin
                phase_nxt = PH_TAIL;
              end else if (byte_value == HDR_SYNC0) begin
                phase_nxt = PH_SYNC;
                fill_nxt  = '0;
                disc_nxt  = held_r;
              end else if (!disc_r) begin
                // last slot stays reserved
                if (fill_r < LW'(BUFFER_DEPTH - 1)) begin
                  wr_en    = 1'b1;
                  fill_nxt = fill_r + LW'(1);
                end else begin
                  disc_nxt = 1'b1;
                end
              end
            end
            PH_TAIL: begin
              if (byte_value == TRL_LF) begin
                if (!disc_r && (fill_r != '0)) begin
                  held_nxt = 1'b1;
                  hlen_nxt = fill_r;
                end
                phase_nxt = PH_HUNT;
              end else if (byte_value == HDR_SYNC0) begin
                phase_nxt = PH_SYNC;
                fill_nxt  = '0;
                disc_nxt  = held_r;
              end else begin
                // broken trailer
                phase_nxt = PH_HUNT;
                fill_nxt  = '0;
                disc_nxt  = 1'b0;
              end
            end
            default: begin
              phase_nxt = PH_HUNT;
            end
          endcase
        end
        ACT_RELEASE: begin
          held_nxt = 1'b0;
          hlen_nxt = '0;
        end
        ACT_LINE_ERR: begin
          phase_nxt = PH_HUNT;
          fill_nxt  = '0;
          disc_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      fill_r  <= '0;
      hlen_r  <= '0;
      held_r  <= 1'b0;
      disc_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      hlen_r  <= hlen_nxt;
      held_r  <= held_nxt;
      disc_r  <= disc_nxt;
    end
  end

  // store write port
  assign wr_addr = fill_r;
  assign wr_data = byte_value;

  // read range check against the held packet
  assign idx_w   = CW'(read_index);
  assign hlen_w  = CW'(hlen_r);
  assign rd_addr = idx_w[LW-1:0];
  assign len_ext = (LW + LEN_W)'(hlen_nxt);

  always_comb begin
    status.held_cur = held_r;
    status.held_nxt = held_nxt;
    status.len_nxt  = held_nxt ? len_ext[LEN_W-1:0] : '0;
    status.rd_hit   = held_r && (idx_w < hlen_w) && (idx_w < CW'(BUFFER_DEPTH));
  end

endmodule

`default_nettype wire

FILE: sv/header_trailer_packet_deframer.sv
// Byte-stream packet deframer, frames of AA 55, payload, 0D 0A.
//
// in_ch carries one transaction per accepted cycle: a received byte, a read
// of a held payload byte by index, a release of the held packet, or a line
// error. out_ch returns exactly one result per input transaction, in order:
// packet status after the transaction, plus read data and read_valid for
// reads (both zero otherwise).
// A transaction accepted on in_ch sits in the input register; when it commits,
// the framer updates, the payload store is written or read and the result
// register loads, with read data taken from the store's registered read port.
// Throughput is one transaction per cycle while out_ch does not stall; the
// framer state loop and the single-port-per-direction store sustain that rate.
// A held packet is never overwritten; frames arriving while one is held are
// dropped. Payload is at most BUFFER_DEPTH-1 bytes.
// Reset (rst_n low, synchronous) returns the framer to header hunt with no
// packet held; payload store contents are not cleared.
// When out_ch stalls, the result register and the input register both hold,
// so up to two transactions are buffered before in_ch.ready drops.
`default_nettype none

module header_trailer_packet_deframer #(
  parameter int unsigned BUFFER_DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  htpd_in_if.sink    in_ch,
  htpd_out_if.source out_ch
);
  import htpd_pkg::*;

  localparam int unsigned LW = $clog2(BUFFER_DEPTH);

  // input register stage
  logic               s1_valid_r, s1_valid_nxt;
  htpd_action_t       s1_action_r;
  logic [7:0]         s1_byte_r;
  logic [IDX_W-1:0]   s1_idx_r;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic               pkt_ready_r;
  logic [LEN_W-1:0]   pkt_len_r;
  logic               rd_valid_r;

  logic               advance;
  logic               commit;
  logic               in_accept;
  logic               rd_en;
  logic [7:0]         rd_data;

  htpd_status_t       stat;
  logic               wr_en;
  logic [LW-1:0]      wr_addr;
  logic [7:0]         wr_data;
  logic [LW-1:0]      rd_addr;

  // pipeline handshake
  assign advance     = !out_valid_r || out_ch.ready;
  assign commit      = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign s1_valid_nxt  = in_accept ? 1'b1 : (commit ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = commit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input payload capture
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= in_ch.action;
      s1_byte_r   <= in_ch.byte_value;
      s1_idx_r    <= in_ch.read_index;
    end
  end

  htpd_framer #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .LW           (LW)
  ) u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (commit),
    .action     (s1_action_r),
    .byte_value (s1_byte_r),
    .read_index (s1_idx_r),
    .status     (stat),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr)
  );

  assign rd_en = commit && (s1_action_r == ACT_READ) && stat.rd_hit;

  htpd_store #(
    .BUFFER_DEPTH (BUFFER_DEPTH),
    .AW           (LW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // result payload capture
  always_ff @(posedge clk) begin
    if (commit) begin
      pkt_ready_r <= stat.held_nxt;
      pkt_len_r   <= stat.len_nxt;
      rd_valid_r  <= rd_en;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.packet_ready  = pkt_ready_r;
  assign out_ch.packet_length = pkt_len_r;
  assign out_ch.read_valid    = rd_valid_r;
  assign out_ch.read_data     = rd_valid_r ? rd_data : 8'h00;

  // a read hit implies a held packet
  a_read_needs_packet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.read_valid) |-> out_ch.packet_ready)
    else $error("read_valid without a held packet");

  // no held packet reports zero length
  a_len_zero_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.packet_ready) |-> (out_ch.packet_length == '0))
    else $error("nonzero length with no packet held");

  // held packet only goes away through a release transaction
  a_held_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.held_cur && !(commit && (s1_action_r == ACT_RELEASE))) |=> stat.held_cur)
    else $error("held packet dropped without release");

  // payload writes never touch a held packet
  a_no_write_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !stat.held_cur)
    else $error("payload store written while a packet is held");

endmodule

`default_nettype wire

FILE: test/header_trailer_packet_deframer_tb.sv
// testbench for the header/trailer packet deframer: random and directed byte streams
`timescale 1ns / 1ps

module header_trailer_packet_deframer_tb;
  import htpd_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam int          HOLD_CYCLES = 300;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          PHASE_ITEMS = 330;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct {
    htpd_action_t action;
    logic [7:0]   byte_value;
    idx_t         read_index;
  } rx_item_t;

  typedef struct {
    logic             packet_ready;
    logic [LEN_W-1:0] packet_length;
    logic [7:0]       read_data;
    logic             read_valid;
  } status_t;

  logic clk = 1'b0;
  logic rst_n;
  logic recv_hold;

  htpd_in_if  in_ch();
  htpd_out_if out_ch();

  header_trailer_packet_deframer #(.BUFFER_DEPTH(DEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #2 clk = ~clk;

  // stimulus and expectation queues
  rx_item_t pending_tx[$];
  status_t  expected_status[$];
  rx_item_t offered_tx;

  int errors         = 0;
  int cycles         = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_asked     = 0;
  int hold_done      = 0;
  int hold_left      = 0;
  int pushed_items   = 0;

  // deframer state as predicted from the accepted transactions
  htpd_phase_t      m_phase;
  logic [5:0]       m_fill;
  logic [LEN_W-1:0] m_held_len;
  logic             m_held;
  logic             m_discard;
  logic [7:0]       m_store [DEPTH];

  function automatic void open_frame(input htpd_phase_t next_phase);
    m_phase   = next_phase;
    m_fill    = '0;
    m_discard = m_held;
  endfunction

  function automatic void frame_byte(input logic [7:0] b);
    case (m_phase)
      PH_HUNT: begin
        if (b == HDR_SYNC0) m_phase = PH_SYNC;
      end
      PH_SYNC: begin
        if (b == HDR_SYNC1) open_frame(PH_BODY);
        else if (b != HDR_SYNC0) m_phase = PH_HUNT;
      end
      PH_BODY: begin
        if (b == TRL_CR) begin
          m_phase = PH_TAIL;
        end else if (b == HDR_SYNC0) begin
          open_frame(PH_SYNC);
        end else if (!m_discard) begin
          // last slot stays reserved, so the frame is marked for drop instead
          if (m_fill < DEPTH - 1) begin
            m_store[m_fill] = b;
            m_fill = m_fill + 1'b1;
          end else begin
            m_discard = 1'b1;
          end
        end
      end
      default: begin
        if (b == TRL_LF) begin
          if (!m_discard && m_fill != 0) begin
            m_held_len = m_fill;
            m_held     = 1'b1;
          end
          m_phase = PH_HUNT;
        end else if (b == HDR_SYNC0) begin
          open_frame(PH_SYNC);
        end else begin
          // broken trailer
          m_phase   = PH_HUNT;
          m_fill    = '0;
          m_discard = 1'b0;
        end
      end
    endcase
  endfunction

  function automatic status_t deframe_predict(input rx_item_t t);
    status_t r;
    r.read_data  = '0;
    r.read_valid = 1'b0;
    case (t.action)
      ACT_BYTE: frame_byte(t.byte_value);
      ACT_READ: begin
        if (m_held && t.read_index < m_held_len) begin
          r.read_data  = m_store[t.read_index];
          r.read_valid = 1'b1;
        end
      end
      ACT_RELEASE: begin
        m_held     = 1'b0;
        m_held_len = '0;
      end
      default: begin
        m_phase   = PH_HUNT;
        m_fill    = '0;
        m_discard = 1'b0;
      end
    endcase
    r.packet_ready  = m_held;
    r.packet_length = m_held ? m_held_len : '0;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // stimulus helpers
  function automatic idx_t rand_idx();
    return idx_t'($urandom_range(62));
  endfunction

  function automatic logic [7:0] payload_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == HDR_SYNC0 || b == TRL_CR) b = b ^ 8'h01;
    return b;
  endfunction

  task automatic push_tx(input htpd_action_t act, input logic [7:0] b, input idx_t idx);
    rx_item_t t;
    t.action     = act;
    t.byte_value = b;
    t.read_index = idx;
    pending_tx.push_back(t);
    pushed_items++;
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_tx(ACT_BYTE, b, rand_idx());
  endtask

  task automatic push_read(input idx_t idx);
    push_tx(ACT_READ, 8'($urandom_range(255)), idx);
  endtask

  task automatic push_op(input htpd_action_t act);
    push_tx(act, 8'($urandom_range(255)), rand_idx());
  endtask

  task automatic push_frame(input int len);
    push_byte(HDR_SYNC0);
    push_byte(HDR_SYNC1);
    for (int i = 0; i < len; i++) push_byte(payload_byte());
    push_byte(TRL_CR);
    push_byte(TRL_LF);
  endtask

  // sender pause: nothing queued, nothing offered, nothing outstanding
  task automatic wait_drained();
    while (pending_tx.size() != 0 || in_ch.valid || expected_status.size() != 0)
      @(posedge clk);
  endtask

  // random traffic, mostly well-formed frames followed by reads and a release
  task automatic gen_random(input int n);
    int start;
    int r;
    int len;
    start = pushed_items;
    while (pushed_items - start < n) begin
      r = $urandom_range(99);
      if (r < 55) begin
        len = $urandom_range(99);
        if (len < 70)      len = $urandom_range(1, 8);
        else if (len < 90) len = $urandom_range(9, 62);
        else if (len < 96) len = 63;
        else               len = $urandom_range(64, 66);
        push_frame(len);
        repeat ($urandom_range(4)) push_read(rand_idx());
        if ($urandom_range(9) < 7) push_op(ACT_RELEASE);
      end else if (r < 65) begin
        push_read(rand_idx());
      end else if (r < 73) begin
        push_op(ACT_RELEASE);
      end else if (r < 77) begin
        push_op(ACT_LINE_ERR);
      end else if (r < 87) begin
        push_byte(8'($urandom_range(255)));
      end else begin
        // broken frames: early restart, bad trailer, or a line error
        push_byte(HDR_SYNC0);
        push_byte(HDR_SYNC1);
        repeat ($urandom_range(3)) push_byte(payload_byte());
        case ($urandom_range(2))
          0: push_byte(HDR_SYNC0);
          1: begin
            push_byte(TRL_CR);
            push_byte(8'($urandom_range(255)));
          end
          default: push_op(ACT_LINE_ERR);
        endcase
      end
    end
  endtask

  // known values before the first edge
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.action     = ACT_BYTE;
    in_ch.byte_value = '0;
    in_ch.read_index = '0;
    out_ch.ready     = 1'b0;
    m_phase    = PH_HUNT;
    m_fill     = '0;
    m_held_len = '0;
    m_held     = 1'b0;
    m_discard  = 1'b0;
  end

  // driver: predicts each accepted transaction, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_status.push_back(deframe_predict(offered_tx));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_tx.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered_tx = pending_tx.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.action     <= offered_tx.action;
          in_ch.byte_value <= offered_tx.byte_value;
          in_ch.read_index <= offered_tx.read_index;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long result-side hold, counted in cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
      recv_hold <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      recv_hold <= 1'b1;
    end else if (hold_done != hold_asked) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
      recv_hold <= 1'b1;
    end else begin
      recv_hold <= 1'b0;
    end
  end

  // monitor: checks results in order and drives the result-side stalls
  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_status.size() == 0) begin
          $error("result transaction with nothing outstanding");
          errors++;
        end else begin
          want = expected_status.pop_front();
          check_field("packet_ready", 8'(want.packet_ready), 8'(out_ch.packet_ready));
          check_field("packet_length", 8'(want.packet_length), 8'(out_ch.packet_length));
          check_field("read_data", want.read_data, out_ch.read_data);
          check_field("read_valid", 8'(want.read_valid), 8'(out_ch.read_valid));
        end
      end
      if (recv_hold) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: status-only actions with nothing held
    push_op(ACT_LINE_ERR);
    push_op(ACT_RELEASE);
    // longest payload; fills every readable slot
    push_frame(DEPTH - 1);
    push_read(idx_t'(0));
    push_read(idx_t'(62));
    // frame while held is dropped, held packet intact
    push_frame(2);
    push_read(idx_t'(1));
    // line error while held keeps the packet
    push_op(ACT_LINE_ERR);
    push_read(idx_t'(30));
    push_op(ACT_RELEASE);
    // read and release with nothing held
    push_read(idx_t'(5));
    push_op(ACT_RELEASE);
    // overlong payload, empty payload
    push_frame(DEPTH);
    push_frame(0);
    // broken trailer
    push_byte(HDR_SYNC0);
    push_byte(HDR_SYNC1);
    push_byte(8'h11);
    push_byte(TRL_CR);
    push_byte(8'h22);
    push_byte(TRL_LF);
    // restart on AA while waiting for 55, inside payload and after CR
    push_byte(HDR_SYNC0);
    push_byte(HDR_SYNC0);
    push_byte(HDR_SYNC1);
    push_byte(8'h33);
    push_byte(HDR_SYNC0);
    push_byte(HDR_SYNC1);
    push_byte(8'hFF);
    push_byte(TRL_CR);
    push_byte(TRL_LF);
    push_read(idx_t'(0));
    push_read(idx_t'(1));
    push_op(ACT_RELEASE);
    push_byte(HDR_SYNC0);
    push_byte(HDR_SYNC1);
    push_byte(8'h66);
    push_byte(TRL_CR);
    push_byte(HDR_SYNC0);
    push_byte(HDR_SYNC1);
    push_byte(8'h00);
    push_byte(TRL_CR);
    push_byte(TRL_LF);
    push_read(idx_t'(0));
    push_op(ACT_RELEASE);
    // line error in the middle of a frame
    push_byte(HDR_SYNC0);
    push_byte(HDR_SYNC1);
    push_byte(8'h12);
    push_op(ACT_LINE_ERR);
    push_byte(TRL_CR);
    push_byte(TRL_LF);
    wait_drained();

    // random: no idling, with one long result-side hold to back up the input
    hold_asked++;
    gen_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct  = 86;
    recv_stall_pct = 0;
    gen_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 86;
    gen_random(PHASE_ITEMS);
    wait_drained();

    send_idle_pct  = 32;
    recv_stall_pct = 32;
    gen_random(PHASE_ITEMS);
    wait_drained();

    repeat (10) @(posedge clk);
    if (errors == 0 && expected_status.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
